[src/srm_pkg.sv]
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and codes of the sixteen-bit register machine step core:
// controller states, command and status bundles, group, op and error codes.
// ----------------------------------------------------------------------------
package srm_pkg;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_ALU,
		ST_DIV,
		ST_PLAN,
		ST_WR1,
		ST_WR2,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic rd1;
		logic rd2;
		logic rd3;
		logic alu;
		logic plan;
		logic wr1;
		logic wr2;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_div;
		logic div_done;
		logic out_free;
	} stat_t;

	// instruction groups
	localparam logic [2:0] GRP_ARITH = 3'd0;
	localparam logic [2:0] GRP_MOVE  = 3'd1;
	localparam logic [2:0] GRP_JUMP  = 3'd2;
	localparam logic [2:0] GRP_CMP   = 3'd3;
	localparam logic [2:0] GRP_MISC  = 3'd4;

	// arithmetic ops
	localparam logic [4:0] ARI_ADD = 5'd0;
	localparam logic [4:0] ARI_SUB = 5'd1;
	localparam logic [4:0] ARI_MUL = 5'd2;
	localparam logic [4:0] ARI_DIV = 5'd3;
	localparam logic [4:0] ARI_REM = 5'd4;
	localparam logic [4:0] ARI_SHL = 5'd5;
	localparam logic [4:0] ARI_SHR = 5'd6;
	localparam logic [4:0] ARI_AND = 5'd7;
	localparam logic [4:0] ARI_OR  = 5'd8;
	localparam logic [4:0] ARI_NOT = 5'd9;
	localparam logic [4:0] ARI_XOR = 5'd10;

	// move ops
	localparam logic [4:0] MOV_MOVE       = 5'd0;
	localparam logic [4:0] MOV_SWAP       = 5'd1;
	localparam logic [4:0] MOV_SWAP_RA    = 5'd2;
	localparam logic [4:0] MOV_SWAP_AA    = 5'd3;
	localparam logic [4:0] MOV_SWAP_RM    = 5'd4;
	localparam logic [4:0] MOV_SWAP_AM    = 5'd5;
	localparam logic [4:0] MOV_SET        = 5'd6;
	localparam logic [4:0] MOV_LOAD       = 5'd7;
	localparam logic [4:0] MOV_LOAD_MEM   = 5'd8;
	localparam logic [4:0] MOV_STORE      = 5'd9;
	localparam logic [4:0] MOV_STORE_ADDR = 5'd10;
	localparam logic [4:0] MOV_STORE_MEM  = 5'd11;
	localparam logic [4:0] MOV_STORE_IMM  = 5'd12;

	// jump ops
	localparam logic [4:0] JMP_IMM        = 5'd0;
	localparam logic [4:0] JMP_IMM_LINK   = 5'd1;
	localparam logic [4:0] JMP_REG        = 5'd2;
	localparam logic [4:0] JMP_REG_LINK   = 5'd3;
	localparam logic [4:0] JMP_IF_F_IMM   = 5'd8;
	localparam logic [4:0] JMP_ITE_T      = 5'd12;
	localparam logic [4:0] JMP_ITE_F      = 5'd13;
	localparam logic [4:0] JMP_ITE_LINK_T = 5'd14;
	localparam logic [4:0] JMP_ITE_LINK_F = 5'd15;

	// kind of a conditional jump, low two op bits
	localparam logic [1:0] JK_IMM      = 2'd0;
	localparam logic [1:0] JK_IMM_LINK = 2'd1;
	localparam logic [1:0] JK_REG      = 2'd2;
	localparam logic [1:0] JK_REG_LINK = 2'd3;

	// compare: relation in op[4:2], mode in op[1:0]
	localparam logic [4:0] CMP_LAST = 5'd23;
	localparam logic [2:0] REL_EQ  = 3'd0;
	localparam logic [2:0] REL_NEQ = 3'd1;
	localparam logic [2:0] REL_LT  = 3'd2;
	localparam logic [2:0] REL_GT  = 3'd3;
	localparam logic [2:0] REL_LE  = 3'd4;
	localparam logic [1:0] MODE_SET = 2'd0;
	localparam logic [1:0] MODE_AND = 2'd1;
	localparam logic [1:0] MODE_OR  = 2'd2;

	// misc ops and system calls
	localparam logic [4:0] MSC_SYS     = 5'd0;
	localparam logic [4:0] MSC_SET_IMM = 5'd1;
	localparam logic [4:0] MSC_SET_IND = 5'd2;
	localparam logic [4:0] MSC_GET_IMM = 5'd3;
	localparam logic [4:0] MSC_GET_IND = 5'd4;
	localparam logic [7:0] SYS_TERM = 8'd0;
	localparam logic [7:0] SYS_GETC = 8'd1;
	localparam logic [7:0] SYS_PUTC = 8'd2;

	// error codes
	localparam logic [3:0] ERR_NONE  = 4'd0;
	localparam logic [3:0] ERR_GROUP = 4'd1;
	localparam logic [3:0] ERR_ARITH = 4'd2;
	localparam logic [3:0] ERR_MOVE  = 4'd3;
	localparam logic [3:0] ERR_JUMP  = 4'd4;
	localparam logic [3:0] ERR_CMP   = 4'd5;
	localparam logic [3:0] ERR_MISC  = 4'd6;
	localparam logic [3:0] ERR_SYS   = 4'd7;
	localparam logic [3:0] ERR_RANGE = 4'd8;

endpackage

[src/srm_div.sv]
// ----------------------------------------------------------------------------
// srm_div
// Iterative 16-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient,
	output logic [15:0] remainder
);
	logic [4:0]  count_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] shifted;
	logic        ge;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[15]};
	assign ge      = shifted >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= busy_q && (count_q == 5'd1);
			if (start) begin
				count_q <= 5'd16;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				count_q <= count_q - 5'd1;
				if (count_q == 5'd1) busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 16'd0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

[src/srm_ctrl.sv]
// ----------------------------------------------------------------------------
// srm_ctrl
// Step sequencer: reads, alu, divide wait, plan, commit WR1/WR2, output load.
// ----------------------------------------------------------------------------
module srm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  srm_pkg::stat_t stat,
	output srm_pkg::cmd_t  cmd
);
	import srm_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RD1;
			ST_RD1:  state_d = ST_RD2;
			ST_RD2:  state_d = ST_RD3;
			ST_RD3:  state_d = ST_ALU;
			ST_ALU:  state_d = stat.needs_div ? ST_DIV : ST_PLAN;
			ST_DIV:  if (stat.div_done) state_d = ST_PLAN;
			ST_PLAN: state_d = ST_WR1;
			ST_WR1:  state_d = ST_WR2;
			ST_WR2:  state_d = ST_DONE;
			ST_DONE: if (stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_RD1:  cmd.rd1 = 1'b1;
			ST_RD2:  cmd.rd2 = 1'b1;
			ST_RD3:  cmd.rd3 = 1'b1;
			ST_ALU:  cmd.alu = 1'b1;
			ST_PLAN: cmd.plan = 1'b1;
			ST_WR1:  cmd.wr1 = 1'b1;
			ST_WR2:  cmd.wr2 = 1'b1;
			ST_DONE: cmd.load_out = stat.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

[src/srm_dpath.sv]
// ----------------------------------------------------------------------------
// srm_dpath
// Datapath: register file, data memory, implicit registers, operand capture,
// alu, step planning with range checks, commit and output register.
// ----------------------------------------------------------------------------
module srm_dpath #(
	parameter int REG_COUNT      = 64,
	parameter int DATA_WORDS     = 65536,
	parameter int IMPLICIT_COUNT = 16,
	parameter int PREDICATE_SLOT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srm_pkg::cmd_t      cmd,
	output srm_pkg::stat_t     stat,
	input  logic [2:0]         group,
	input  logic [4:0]         op,
	input  logic [7:0]         reg_a,
	input  logic [7:0]         reg_b,
	input  logic [7:0]         reg_c,
	input  logic [15:0]        immediate,
	input  logic [7:0]         misc_index,
	input  logic signed [8:0]  console_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_pc,
	output logic               console_out_valid,
	output logic [7:0]         console_out,
	output logic               console_in_used,
	output logic               halted,
	output logic [3:0]         error_code
);
	import srm_pkg::*;

	localparam int RAW = $clog2(REG_COUNT);
	localparam int DAW = $clog2(DATA_WORDS);
	localparam int IAW = (IMPLICIT_COUNT > 1) ? $clog2(IMPLICIT_COUNT) : 1;
	localparam logic PRED_OK = PREDICATE_SLOT < IMPLICIT_COUNT;
	localparam logic [IAW-1:0] PRED_ADDR = IAW'(PREDICATE_SLOT);

	// latched item
	logic [2:0]  grp_q;
	logic [4:0]  op_q;
	logic [7:0]  ra_q, rb_q, rc_q, mi_q;
	logic [15:0] imm_q;
	logic [8:0]  cin_q;

	// operands
	logic [15:0] va_q, vb_q, vc_q, vp_q, ma_q, mb_q, alu_q;
	logic [7:0]  i0_q, i1_q;

	// architectural state
	logic [15:0] pc_q;
	logic        stopped_q;

	// storage
	logic [15:0] rf_mem [REG_COUNT];
	logic [15:0] dm_mem [DATA_WORDS];
	logic [7:0]  imp_mem [IMPLICIT_COUNT];
	logic [IMPLICIT_COUNT-1:0] imp_vld_q;

	logic [15:0] rf_rd0_q, rf_rd1_q, dm_rd_q;
	logic [7:0]  imp_raw_q;
	logic        imp_hit_q;
	logic [7:0]  imp_rd;

	// plan registers
	logic        rw0_en_q, rw1_en_q, mw0_en_q, mw1_en_q, iw_en_q;
	logic [7:0]  rw0_addr_q, rw1_addr_q, iw_addr_q;
	logic [15:0] rw0_data_q, rw1_data_q, mw0_addr_q, mw1_addr_q, mw0_data_q, mw1_data_q;
	logic [7:0]  iw_data_q;
	logic [15:0] npc_q;
	logic [3:0]  err_q;
	logic        halt_q, put_q, got_q;
	logic [7:0]  pbyte_q;

	// plan logic
	logic        p_rw0_en, p_rw1_en, p_mw0_en, p_mw1_en, p_iw_en;
	logic [7:0]  p_rw0_addr, p_rw1_addr, p_iw_addr;
	logic [15:0] p_rw0_data, p_rw1_data, p_mw0_addr, p_mw1_addr, p_mw0_data, p_mw1_data;
	logic [7:0]  p_iw_data;
	logic [15:0] p_npc, p_pv;
	logic [3:0]  p_inv, p_err;
	logic        p_bad, p_term, p_put, p_got, p_cond, p_want, p_rel;

	logic        ok_a, ok_b, ok_c, ok_m, ok_pi, imp_m, imp_a, imp_x;
	logic [15:0] link, alu_d, cin_ext;
	logic [31:0] prod;

	// port addresses and write data
	logic [RAW-1:0] rf_ra0, rf_ra1, rf_wa;
	logic [15:0]    rf_wd;
	logic           rf_we, rf_re;
	logic [15:0]    dm_ra, dm_wa, dm_wd;
	logic           dm_we, dm_re;
	logic [IAW-1:0] imp_ra;
	logic           imp_re;

	// divider
	logic        div_done;
	logic [15:0] div_quo, div_rem;

	function automatic logic addr_ok(input logic [15:0] a);
		return 17'(a) < 17'(DATA_WORDS);
	endfunction

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			grp_q <= group;
			op_q  <= op;
			ra_q  <= reg_a;
			rb_q  <= reg_b;
			rc_q  <= reg_c;
			imm_q <= immediate;
			mi_q  <= misc_index;
			cin_q <= console_in;
		end
	end

	// register file ports
	always_comb begin
		rf_re  = cmd.rd1 | cmd.rd2;
		rf_ra0 = cmd.rd1 ? ra_q[RAW-1:0] : rc_q[RAW-1:0];
		if (cmd.rd1)                rf_ra1 = rb_q[RAW-1:0];
		else if (grp_q == GRP_MISC) rf_ra1 = mi_q[RAW-1:0];
		else                        rf_ra1 = imp_rd[RAW-1:0];
		rf_we = (cmd.wr1 & rw0_en_q) | (cmd.wr2 & rw1_en_q);
		rf_wa = cmd.wr1 ? rw0_addr_q[RAW-1:0] : rw1_addr_q[RAW-1:0];
		rf_wd = cmd.wr1 ? rw0_data_q : rw1_data_q;
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		if (rf_re) begin
			rf_rd0_q <= rf_mem[rf_ra0];
			rf_rd1_q <= rf_mem[rf_ra1];
		end
	end

	// data memory port
	always_comb begin
		dm_re = cmd.rd2 | cmd.rd3;
		if (cmd.rd3) begin
			dm_ra = (op_q == MOV_SWAP_AM) ? imm_q : vb_q;
		end else begin
			case (op_q)
				MOV_SWAP_RM, MOV_LOAD_MEM, MOV_STORE_MEM: dm_ra = imm_q;
				MOV_SWAP_RA, MOV_LOAD, MOV_STORE_ADDR:    dm_ra = rf_rd1_q;
				default:                                  dm_ra = rf_rd0_q;
			endcase
		end
		dm_we = (cmd.wr1 & mw0_en_q) | (cmd.wr2 & mw1_en_q);
		dm_wa = cmd.wr1 ? mw0_addr_q : mw1_addr_q;
		dm_wd = cmd.wr1 ? mw0_data_q : mw1_data_q;
	end

	always_ff @(posedge clk) begin
		if (dm_we) dm_mem[dm_wa[DAW-1:0]] <= dm_wd;
		if (dm_re) dm_rd_q <= dm_mem[dm_ra[DAW-1:0]];
	end

	// implicit registers, valid bits give the reset value of zero
	always_comb begin
		imp_re = cmd.rd1 | cmd.rd3;
		if (cmd.rd3)                imp_ra = rf_rd1_q[IAW-1:0];
		else if (grp_q == GRP_MISC) imp_ra = ra_q[IAW-1:0];
		else                        imp_ra = PRED_ADDR;
		imp_rd = imp_hit_q ? imp_raw_q : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr1 && iw_en_q) imp_mem[iw_addr_q[IAW-1:0]] <= iw_data_q;
		if (imp_re) imp_raw_q <= imp_mem[imp_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imp_vld_q <= '0;
			imp_hit_q <= 1'b0;
		end else begin
			if (cmd.wr1 && iw_en_q) imp_vld_q[iw_addr_q[IAW-1:0]] <= 1'b1;
			if (imp_re) imp_hit_q <= imp_vld_q[imp_ra];
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.rd2) begin
			va_q <= rf_rd0_q;
			vb_q <= rf_rd1_q;
			i0_q <= imp_rd;
		end
		if (cmd.rd3) begin
			vc_q <= rf_rd0_q;
			vp_q <= rf_rd1_q;
			ma_q <= dm_rd_q;
		end
		if (cmd.alu) begin
			mb_q  <= dm_rd_q;
			i1_q  <= imp_rd;
			alu_q <= alu_d;
		end else if (div_done) begin
			if (op_q == ARI_REM) alu_q <= (vc_q == 16'd0) ? vb_q : div_rem;
			else                 alu_q <= (vc_q == 16'd0) ? 16'hFFFF : div_quo;
		end
	end

	// alu
	assign prod = vb_q * vc_q;
	always_comb begin
		case (op_q)
			ARI_ADD: alu_d = vb_q + vc_q;
			ARI_SUB: alu_d = vb_q - vc_q;
			ARI_MUL: alu_d = prod[15:0];
			ARI_SHL: alu_d = (vc_q < 16'd16) ? (vb_q << vc_q[3:0]) : 16'd0;
			ARI_SHR: alu_d = (vc_q < 16'd16) ? (vb_q >> vc_q[3:0]) : 16'd0;
			ARI_AND: alu_d = vb_q & vc_q;
			ARI_OR:  alu_d = vb_q | vc_q;
			ARI_XOR: alu_d = vb_q ^ vc_q;
			default: alu_d = vb_q;
		endcase
	end

	srm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.alu & stat.needs_div),
		.dividend  (vb_q),
		.divisor   (vc_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// range checks
	always_comb begin
		ok_a    = 9'(ra_q) < 9'(REG_COUNT);
		ok_b    = 9'(rb_q) < 9'(REG_COUNT);
		ok_c    = 9'(rc_q) < 9'(REG_COUNT);
		ok_m    = 9'(mi_q) < 9'(REG_COUNT);
		ok_pi   = 9'(i0_q) < 9'(REG_COUNT);
		imp_m   = 9'(mi_q) < 9'(IMPLICIT_COUNT);
		imp_a   = 9'(ra_q) < 9'(IMPLICIT_COUNT);
		imp_x   = 9'(vp_q[7:0]) < 9'(IMPLICIT_COUNT);
		link    = pc_q + 16'd1;
		cin_ext = {{7{cin_q[8]}}, cin_q};
	end

	// step plan: writes, next pc and fault of the current instruction
	always_comb begin
		p_rw0_en = 1'b0; p_rw0_addr = ra_q; p_rw0_data = 16'd0;
		p_rw1_en = 1'b0; p_rw1_addr = rb_q; p_rw1_data = va_q;
		p_mw0_en = 1'b0; p_mw0_addr = va_q; p_mw0_data = 16'd0;
		p_mw1_en = 1'b0; p_mw1_addr = vb_q; p_mw1_data = ma_q;
		p_iw_en  = 1'b0; p_iw_addr  = mi_q; p_iw_data  = va_q[7:0];
		p_npc  = link;
		p_inv  = ERR_NONE;
		p_bad  = 1'b0;
		p_term = 1'b0;
		p_put  = 1'b0;
		p_got  = 1'b0;
		p_cond = 1'b0;
		p_want = op_q < JMP_IF_F_IMM;
		p_rel  = 1'b0;
		p_pv   = (i0_q == ra_q) ? link : vp_q;
		case (grp_q)
			GRP_ARITH: begin
				if (op_q > ARI_XOR) p_inv = ERR_ARITH;
				else begin
					p_rw0_en = 1'b1;
					if (op_q == ARI_NOT) begin
						p_bad = !ok_b || !ok_a;
						p_rw0_data = ~vb_q;
					end else begin
						p_bad = !ok_b || !ok_c || !ok_a;
						p_rw0_data = alu_q;
					end
				end
			end
			GRP_MOVE: begin
				case (op_q)
					MOV_MOVE: begin
						p_bad = !ok_b || !ok_a;
						p_rw0_en = 1'b1; p_rw0_data = vb_q;
					end
					MOV_SWAP: begin
						p_bad = !ok_a || !ok_b;
						p_rw0_en = 1'b1; p_rw0_data = vb_q;
						p_rw1_en = 1'b1;
					end
					MOV_SWAP_RA: begin
						p_bad = !ok_b || !ok_a || !addr_ok(vb_q);
						p_rw0_en = 1'b1; p_rw0_data = ma_q;
						p_mw0_en = 1'b1; p_mw0_addr = vb_q; p_mw0_data = va_q;
					end
					MOV_SWAP_AA: begin
						p_bad = !ok_a || !ok_b || !addr_ok(va_q) || !addr_ok(vb_q);
						p_mw0_en = 1'b1; p_mw0_data = mb_q;
						p_mw1_en = 1'b1;
					end
					MOV_SWAP_RM: begin
						p_bad = !ok_a || !addr_ok(imm_q);
						p_rw0_en = 1'b1; p_rw0_data = ma_q;
						p_mw0_en = 1'b1; p_mw0_addr = imm_q; p_mw0_data = va_q;
					end
					MOV_SWAP_AM: begin
						p_bad = !ok_a || !addr_ok(va_q) || !addr_ok(imm_q);
						p_mw0_en = 1'b1; p_mw0_data = mb_q;
						p_mw1_en = 1'b1; p_mw1_addr = imm_q;
					end
					MOV_SET: begin
						p_bad = !ok_a;
						p_rw0_en = 1'b1; p_rw0_data = imm_q;
					end
					MOV_LOAD: begin
						p_bad = !ok_b || !addr_ok(vb_q) || !ok_a;
						p_rw0_en = 1'b1; p_rw0_data = ma_q;
					end
					MOV_LOAD_MEM: begin
						p_bad = !addr_ok(imm_q) || !ok_a;
						p_rw0_en = 1'b1; p_rw0_data = ma_q;
					end
					MOV_STORE: begin
						p_bad = !ok_a || !ok_b || !addr_ok(va_q);
						p_mw0_en = 1'b1; p_mw0_data = vb_q;
					end
					MOV_STORE_ADDR: begin
						p_bad = !ok_a || !ok_b || !addr_ok(vb_q) || !addr_ok(va_q);
						p_mw0_en = 1'b1; p_mw0_data = ma_q;
					end
					MOV_STORE_MEM: begin
						p_bad = !ok_a || !addr_ok(imm_q) || !addr_ok(va_q);
						p_mw0_en = 1'b1; p_mw0_data = ma_q;
					end
					MOV_STORE_IMM: begin
						p_bad = !ok_a || !addr_ok(va_q);
						p_mw0_en = 1'b1; p_mw0_data = imm_q;
					end
					default: p_inv = ERR_MOVE;
				endcase
			end
			GRP_JUMP: begin
				p_rw0_data = link;
				if (op_q > JMP_ITE_LINK_F) p_inv = ERR_JUMP;
				else begin
					case (op_q)
						JMP_IMM: p_npc = imm_q;
						JMP_IMM_LINK: begin
							p_bad = !ok_a;
							p_rw0_en = 1'b1;
							p_npc = imm_q;
						end
						JMP_REG: begin
							p_bad = !ok_a;
							p_npc = va_q;
						end
						JMP_REG_LINK: begin
							p_bad = !ok_a || !ok_b;
							p_rw0_en = 1'b1;
							p_npc = (rb_q == ra_q) ? link : vb_q;
						end
						JMP_ITE_T, JMP_ITE_F: begin
							p_cond = (va_q != 16'd0) == (op_q == JMP_ITE_T);
							p_bad = !ok_a || (p_cond ? !ok_b : !ok_c);
							p_npc = p_cond ? vb_q : vc_q;
						end
						JMP_ITE_LINK_T, JMP_ITE_LINK_F: begin
							// the link write lands before the predicate and target reads
							p_rw0_en = 1'b1;
							p_cond = (p_pv != 16'd0) == (op_q == JMP_ITE_LINK_T);
							p_bad = !ok_a || !PRED_OK || !ok_pi || (p_cond ? !ok_b : !ok_c);
							if (p_cond) p_npc = (rb_q == ra_q) ? link : vb_q;
							else        p_npc = (rc_q == ra_q) ? link : vc_q;
						end
						default: begin
							case (op_q[1:0])
								JK_IMM: begin
									p_cond = (va_q != 16'd0) == p_want;
									p_bad = !ok_a;
									p_npc = p_cond ? imm_q : link;
								end
								JK_IMM_LINK: begin
									p_cond = (vp_q != 16'd0) == p_want;
									p_bad = !PRED_OK || !ok_pi || (p_cond && !ok_a);
									p_rw0_en = p_cond;
									p_npc = p_cond ? imm_q : link;
								end
								JK_REG: begin
									p_cond = (va_q != 16'd0) == p_want;
									p_bad = !ok_a || (p_cond && !ok_b);
									p_npc = p_cond ? vb_q : link;
								end
								default: begin
									// link into reg_b, then target from reg_c
									p_cond = (va_q != 16'd0) == p_want;
									p_bad = !ok_a || (p_cond && (!ok_b || !ok_c));
									p_rw0_en = p_cond;
									p_rw0_addr = rb_q;
									if (p_cond) p_npc = (rc_q == rb_q) ? link : vc_q;
								end
							endcase
						end
					endcase
				end
			end
			GRP_CMP: begin
				if (op_q > CMP_LAST) p_inv = ok_a ? ERR_CMP : ERR_RANGE;
				else begin
					p_bad = !ok_a || !ok_b || !ok_c;
					case (op_q[4:2])
						REL_EQ:  p_rel = vb_q == vc_q;
						REL_NEQ: p_rel = vb_q != vc_q;
						REL_LT:  p_rel = vb_q < vc_q;
						REL_GT:  p_rel = vb_q > vc_q;
						REL_LE:  p_rel = vb_q <= vc_q;
						default: p_rel = vb_q >= vc_q;
					endcase
					p_rw0_en = 1'b1;
					case (op_q[1:0])
						MODE_SET: p_rw0_data = {15'd0, p_rel};
						MODE_AND: p_rw0_data = va_q & {15'd0, p_rel};
						MODE_OR:  p_rw0_data = va_q | {15'd0, p_rel};
						default:  p_rw0_data = va_q ^ {15'd0, p_rel};
					endcase
				end
			end
			GRP_MISC: begin
				case (op_q)
					MSC_SYS: begin
						case (mi_q)
							SYS_TERM: p_term = 1'b1;
							SYS_GETC: begin
								p_bad = !ok_a;
								p_rw0_en = 1'b1; p_rw0_data = cin_ext;
								p_got = 1'b1;
							end
							SYS_PUTC: begin
								p_bad = !ok_a;
								p_put = 1'b1;
							end
							default: p_inv = ERR_SYS;
						endcase
					end
					MSC_SET_IMM: begin
						p_bad = !ok_a || !imp_m;
						p_iw_en = 1'b1;
					end
					MSC_SET_IND: begin
						p_bad = !ok_m || !ok_a || !imp_x;
						p_iw_en = 1'b1; p_iw_addr = vp_q[7:0];
					end
					MSC_GET_IMM: begin
						p_bad = !imp_a || !ok_m;
						p_rw0_en = 1'b1; p_rw0_addr = mi_q; p_rw0_data = {8'd0, i0_q};
					end
					MSC_GET_IND: begin
						p_bad = !ok_m || !imp_x || !ok_a;
						p_rw0_en = 1'b1; p_rw0_data = {8'd0, i1_q};
					end
					default: p_inv = ERR_MISC;
				endcase
			end
			default: p_inv = ERR_GROUP;
		endcase
		// an invalid op is seen before any index, save reg_a of a compare
		if (p_inv != ERR_NONE) p_err = p_inv;
		else if (p_bad)        p_err = ERR_RANGE;
		else                   p_err = ERR_NONE;
	end

	// plan register; a fault or a stopped machine changes only the stop flag
	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			rw0_addr_q <= p_rw0_addr; rw0_data_q <= p_rw0_data;
			rw1_addr_q <= p_rw1_addr; rw1_data_q <= p_rw1_data;
			mw0_addr_q <= p_mw0_addr; mw0_data_q <= p_mw0_data;
			mw1_addr_q <= p_mw1_addr; mw1_data_q <= p_mw1_data;
			iw_addr_q  <= p_iw_addr;  iw_data_q  <= p_iw_data;
			pbyte_q    <= p_put ? va_q[7:0] : 8'd0;
			if (stopped_q || p_err != ERR_NONE) begin
				rw0_en_q <= 1'b0; rw1_en_q <= 1'b0;
				mw0_en_q <= 1'b0; mw1_en_q <= 1'b0;
				iw_en_q  <= 1'b0;
				npc_q    <= pc_q;
				halt_q   <= 1'b1;
				err_q    <= stopped_q ? ERR_NONE : p_err;
				put_q    <= 1'b0;
				got_q    <= 1'b0;
			end else begin
				rw0_en_q <= p_rw0_en; rw1_en_q <= p_rw1_en;
				mw0_en_q <= p_mw0_en; mw1_en_q <= p_mw1_en;
				iw_en_q  <= p_iw_en;
				npc_q    <= p_npc;
				halt_q   <= p_term;
				err_q    <= ERR_NONE;
				put_q    <= p_put;
				got_q    <= p_got;
			end
		end
	end

	// program counter and stop flag commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 16'd0;
			stopped_q <= 1'b0;
		end else if (cmd.wr1) begin
			pc_q      <= npc_q;
			stopped_q <= halt_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_out) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			next_pc           <= npc_q;
			console_out_valid <= put_q;
			console_out       <= put_q ? pbyte_q : 8'd0;
			console_in_used   <= got_q;
			halted            <= halt_q;
			error_code        <= err_q;
		end
	end

	// status
	assign stat.needs_div = (grp_q == GRP_ARITH) && (op_q == ARI_DIV || op_q == ARI_REM);
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid || out_ready;
endmodule

[src/sixteen_bit_register_machine_step_core.sv]
// ----------------------------------------------------------------------------
// sixteen_bit_register_machine_step_core
// Executes one decoded instruction per item against a 16-bit register file,
// data memory, program counter and implicit registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one decoded instruction per item;
//   output channel out_valid/out_ready carries one result item per input item.
//   Each item goes through the read states RD1, RD2 and RD3 (register file,
//   data memory and implicit registers, two register ports and one memory
//   port), an alu state, a plan state and the commit states WR1 and WR2 (one
//   register and one memory write port). The next item is taken only after
//   the result is loaded into the output register. Divide and remainder use
//   a bit-serial divider and wait in a divide state until it is done.
//   in_ready is high only while no item is in flight.
//   Reset clears the program counter, the implicit registers and the stop flag;
//   register file and data memory contents are undefined until written.
//   A stalled receiver holds the result in the output register; the core
//   waits with its finished item until that register is free.
// ----------------------------------------------------------------------------
module sixteen_bit_register_machine_step_core #(
	parameter int REG_COUNT      = 64,
	parameter int DATA_WORDS     = 65536,
	parameter int IMPLICIT_COUNT = 16,
	parameter int PREDICATE_SLOT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        group,
	input  logic [4:0]        op,
	input  logic [7:0]        reg_a,
	input  logic [7:0]        reg_b,
	input  logic [7:0]        reg_c,
	input  logic [15:0]       immediate,
	input  logic [7:0]        misc_index,
	input  logic signed [8:0] console_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       next_pc,
	output logic              console_out_valid,
	output logic [7:0]        console_out,
	output logic              console_in_used,
	output logic              halted,
	output logic [3:0]        error_code
);
	import srm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	srm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	srm_dpath #(
		.REG_COUNT      (REG_COUNT),
		.DATA_WORDS     (DATA_WORDS),
		.IMPLICIT_COUNT (IMPLICIT_COUNT),
		.PREDICATE_SLOT (PREDICATE_SLOT)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.group             (group),
		.op                (op),
		.reg_a             (reg_a),
		.reg_b             (reg_b),
		.reg_c             (reg_c),
		.immediate         (immediate),
		.misc_index        (misc_index),
		.console_in        (console_in),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.next_pc           (next_pc),
		.console_out_valid (console_out_valid),
		.console_out       (console_out),
		.console_in_used   (console_in_used),
		.halted            (halted),
		.error_code        (error_code)
	);
endmodule

[src/srm_chk.sv]
// ----------------------------------------------------------------------------
// srm_chk
// Port-level checks of the step core, attached by bind.
// ----------------------------------------------------------------------------
module srm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [15:0]       next_pc,
	input logic              console_out_valid,
	input logic [7:0]        console_out,
	input logic              console_in_used,
	input logic              halted,
	input logic [3:0]        error_code
);
	import srm_pkg::*;

	// an error always halts
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> halted)
		else $error("error without halt");

	// a faulted step has no console side effects
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !console_out_valid && !console_in_used)
		else $error("console activity on a faulted step");

	// console byte is zero unless a put-char was issued
	a_putc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !console_out_valid |-> console_out == 8'd0)
		else $error("console byte without put-char");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("result changed under stall");
endmodule

bind sixteen_bit_register_machine_step_core srm_chk u_chk (.*);

[verif/tb_sixteen_bit_register_machine_step_core.sv]
// ----------------------------------------------------------------------------
// tb_sixteen_bit_register_machine_step_core
// Self-checking bench for the register machine step core. A directed table
// covers reset state, extreme values and the arithmetic corner cases. It is
// followed by random instructions that are filtered so that every register
// and memory word read has been written before. A halting instruction and
// three more close the run. Each result is compared with a behavioral copy of
// the machine, with random stalls on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_sixteen_bit_register_machine_step_core;
	import srm_pkg::*;

	typedef struct packed {
		logic [2:0]        group;
		logic [4:0]        op;
		logic [7:0]        ra;
		logic [7:0]        rb;
		logic [7:0]        rc;
		logic [15:0]       imm;
		logic [7:0]        mi;
		logic signed [8:0] cin;
	} instr_t;

	typedef struct packed {
		logic [15:0] pc;
		logic        cov;
		logic [7:0]  co;
		logic        ciu;
		logic        halted;
		logic [3:0]  err;
	} res_t;

	typedef struct packed {
		instr_t      ins;
		logic        chk;
		logic [15:0] exp_pc;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        group;
	logic [4:0]        op;
	logic [7:0]        reg_a;
	logic [7:0]        reg_b;
	logic [7:0]        reg_c;
	logic [15:0]       immediate;
	logic [7:0]        misc_index;
	logic signed [8:0] console_in;
	logic              out_valid;
	logic              out_ready;
	logic [15:0]       next_pc;
	logic              console_out_valid;
	logic [7:0]        console_out;
	logic              console_in_used;
	logic              halted;
	logic [3:0]        error_code;

	sixteen_bit_register_machine_step_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.group(group), .op(op), .reg_a(reg_a), .reg_b(reg_b), .reg_c(reg_c),
		.immediate(immediate), .misc_index(misc_index), .console_in(console_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .console_out_valid(console_out_valid),
		.console_out(console_out), .console_in_used(console_in_used),
		.halted(halted), .error_code(error_code)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// machine state as the bench sees it
	logic [15:0] mreg [64];
	bit          mreg_ok [64];
	logic [7:0]  mimp [16];
	logic [15:0] mem [logic [15:0]];
	logic [15:0] mpc;
	bit          mstop;

	// scratch copies for one instruction
	logic [15:0] sreg [64];
	bit          sok [64];
	logic [7:0]  simp [16];
	logic [3:0]  fault;
	bit          undef;
	logic [15:0] pa [2];
	logic [15:0] pv [2];
	int          pn;

	res_t pending_results[$];
	int   fails;
	int   results_seen;
	int   random_items;
	int   halt_code;

	function automatic void flag(logic [3:0] c);
		if (fault == ERR_NONE) fault = c;
	endfunction

	function automatic logic [15:0] rd(int i);
		if (i >= 64) begin
			flag(ERR_RANGE);
			return 16'd0;
		end
		if (!sok[i]) undef = 1;
		return sreg[i];
	endfunction

	function automatic void wr(int i, logic [15:0] v);
		if (i >= 64) begin
			flag(ERR_RANGE);
			return;
		end
		sreg[i] = v;
		sok[i] = 1;
	endfunction

	function automatic logic [15:0] mrd(logic [15:0] a);
		if (!mem.exists(a)) begin
			undef = 1;
			return 16'd0;
		end
		return mem[a];
	endfunction

	function automatic void mwr(logic [15:0] a, logic [15:0] v);
		if (pn < 2) begin
			pa[pn] = a;
			pv[pn] = v;
			pn++;
		end
	endfunction

	function automatic logic [7:0] imp_rd(int i);
		if (i >= 16) begin
			flag(ERR_RANGE);
			return 8'd0;
		end
		return simp[i];
	endfunction

	function automatic void imp_wr(int i, logic [7:0] v);
		if (i >= 16) flag(ERR_RANGE);
		else simp[i] = v;
	endfunction

	function automatic logic [15:0] pred_val();
		logic [7:0] idx;
		idx = imp_rd(0);
		if (fault != ERR_NONE) return 16'd0;
		return rd(idx);
	endfunction

	function automatic void exec_arith(logic [4:0] o, int d, int s0, int s1);
		logic [15:0] a, b, r;
		if (o > ARI_XOR) begin
			flag(ERR_ARITH);
			return;
		end
		if (o == ARI_NOT) begin
			wr(d, ~rd(s0));
			return;
		end
		a = rd(s0);
		b = rd(s1);
		case (o)
			ARI_ADD: r = a + b;
			ARI_SUB: r = a - b;
			ARI_MUL: r = a * b;
			ARI_DIV: r = (b != 0) ? a / b : 16'hFFFF;
			ARI_REM: r = (b != 0) ? a % b : a;
			ARI_SHL: r = (b < 16) ? a << b : 16'd0;
			ARI_SHR: r = (b < 16) ? a >> b : 16'd0;
			ARI_AND: r = a & b;
			ARI_OR:  r = a | b;
			default: r = a ^ b;
		endcase
		wr(d, r);
	endfunction

	function automatic void exec_move(logic [4:0] o, int r0, int r1, logic [15:0] imm);
		logic [15:0] a, b, x, y;
		case (o)
			MOV_MOVE: wr(r0, rd(r1));
			MOV_SWAP: begin
				a = rd(r0); b = rd(r1); wr(r0, b); wr(r1, a);
			end
			MOV_SWAP_RA: begin
				x = rd(r1); a = rd(r0); b = mrd(x); wr(r0, b); mwr(x, a);
			end
			MOV_SWAP_AA: begin
				x = rd(r0); y = rd(r1); a = mrd(x); b = mrd(y); mwr(x, b); mwr(y, a);
			end
			MOV_SWAP_RM: begin
				a = rd(r0); b = mrd(imm); wr(r0, b); mwr(imm, a);
			end
			MOV_SWAP_AM: begin
				x = rd(r0); a = mrd(x); b = mrd(imm); mwr(x, b); mwr(imm, a);
			end
			MOV_SET: wr(r0, imm);
			MOV_LOAD: begin
				x = rd(r1); wr(r0, mrd(x));
			end
			MOV_LOAD_MEM: wr(r0, mrd(imm));
			MOV_STORE: begin
				x = rd(r0); a = rd(r1); mwr(x, a);
			end
			MOV_STORE_ADDR: begin
				x = rd(r0); y = rd(r1); mwr(x, mrd(y));
			end
			MOV_STORE_MEM: begin
				x = rd(r0); mwr(x, mrd(imm));
			end
			MOV_STORE_IMM: begin
				x = rd(r0); mwr(x, imm);
			end
			default: flag(ERR_MOVE);
		endcase
	endfunction

	// returns the pc after the jump
	function automatic logic [15:0] exec_jump(logic [4:0] o, int r0, int r1, int r2,
			logic [15:0] imm, logic [15:0] pc);
		logic [15:0] link;
		bit want, c;
		link = pc + 16'd1;
		if (o > JMP_ITE_LINK_F) begin
			flag(ERR_JUMP);
			return pc;
		end
		case (o)
			JMP_IMM: return imm;
			JMP_IMM_LINK: begin
				wr(r0, link); return imm;
			end
			JMP_REG: return rd(r0);
			JMP_REG_LINK: begin
				wr(r0, link); return rd(r1);
			end
			JMP_ITE_T: return (rd(r0) != 0) ? rd(r1) : rd(r2);
			JMP_ITE_F: return (rd(r0) == 0) ? rd(r1) : rd(r2);
			JMP_ITE_LINK_T: begin
				wr(r0, link); return (pred_val() != 0) ? rd(r1) : rd(r2);
			end
			JMP_ITE_LINK_F: begin
				wr(r0, link); return (pred_val() == 0) ? rd(r1) : rd(r2);
			end
			default: ;
		endcase
		want = o < JMP_IF_F_IMM;
		case (o[1:0])
			JK_IMM: begin
				c = (rd(r0) != 0) == want;
				return c ? imm : link;
			end
			JK_IMM_LINK: begin
				c = (pred_val() != 0) == want;
				if (!c) return link;
				wr(r0, link);
				return imm;
			end
			JK_REG: begin
				c = (rd(r0) != 0) == want;
				return c ? rd(r1) : link;
			end
			default: begin
				c = (rd(r0) != 0) == want;
				if (!c) return link;
				wr(r1, link);
				return rd(r2);
			end
		endcase
	endfunction

	function automatic void exec_compare(logic [4:0] o, int r0, int r1, int r2);
		logic [15:0] v, a, b, rel;
		v = rd(r0);
		if (o > CMP_LAST) begin
			flag(ERR_CMP);
			return;
		end
		a = rd(r1);
		b = rd(r2);
		case (o[4:2])
			REL_EQ:  rel = a == b;
			REL_NEQ: rel = a != b;
			REL_LT:  rel = a < b;
			REL_GT:  rel = a > b;
			REL_LE:  rel = a <= b;
			default: rel = a >= b;
		endcase
		case (o[1:0])
			MODE_SET: v = rel;
			MODE_AND: v &= rel;
			MODE_OR:  v |= rel;
			default:  v ^= rel;
		endcase
		wr(r0, v);
	endfunction

	// result of one instruction; state is updated only when commit is set
	function automatic void run_instruction(input instr_t it, input bit commit,
			output res_t r, output bit bad);
		logic [15:0] npc, v, ix;
		bit term;
		r = '0;
		bad = 0;
		if (mstop) begin
			r.pc = mpc;
			r.halted = 1;
			return;
		end
		sreg = mreg; sok = mreg_ok; simp = mimp;
		fault = ERR_NONE; undef = 0; pn = 0;
		npc = mpc + 16'd1;
		term = 0;
		case (it.group)
			GRP_ARITH: exec_arith(it.op, it.ra, it.rb, it.rc);
			GRP_MOVE:  exec_move(it.op, it.ra, it.rb, it.imm);
			GRP_JUMP:  npc = exec_jump(it.op, it.ra, it.rb, it.rc, it.imm, mpc);
			GRP_CMP:   exec_compare(it.op, it.ra, it.rb, it.rc);
			GRP_MISC: begin
				case (it.op)
					MSC_SYS: begin
						if (it.mi == SYS_TERM) term = 1;
						else if (it.mi == SYS_GETC) begin
							wr(it.ra, {{7{it.cin[8]}}, it.cin});
							r.ciu = 1;
						end else if (it.mi == SYS_PUTC) begin
							r.co = rd(it.ra);
							r.cov = 1;
						end else flag(ERR_SYS);
					end
					MSC_SET_IMM: begin
						v = rd(it.ra); imp_wr(it.mi, v[7:0]);
					end
					MSC_SET_IND: begin
						ix = rd(it.mi); v = rd(it.ra); imp_wr(ix[7:0], v[7:0]);
					end
					MSC_GET_IMM: wr(it.mi, imp_rd(it.ra));
					MSC_GET_IND: begin
						ix = rd(it.mi); wr(it.ra, imp_rd(ix[7:0]));
					end
					default: flag(ERR_MISC);
				endcase
			end
			default: flag(ERR_GROUP);
		endcase
		bad = undef;
		if (fault != ERR_NONE) begin
			r = '0;
			r.pc = mpc;
			r.halted = 1;
			r.err = fault;
			if (commit) mstop = 1;
			return;
		end
		r.pc = npc;
		r.halted = term;
		if (!commit) return;
		mreg = sreg; mreg_ok = sok; mimp = simp;
		for (int i = 0; i < pn; i++) mem[pa[i]] = pv[i];
		mpc = npc;
		if (term) mstop = 1;
	endfunction

	// random index, mostly inside the given bound
	function automatic logic [7:0] pick_idx(int bound);
		return ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, bound - 1))
			: 8'($urandom_range(0, 255));
	endfunction

	function automatic instr_t draw_instr();
		instr_t it;
		it.group = 3'($urandom_range(0, 4));
		it.ra = pick_idx(64);
		it.rb = pick_idx(64);
		it.rc = pick_idx(64);
		it.imm = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15))
			: 16'($urandom_range(0, 65535));
		it.mi = 8'($urandom_range(0, 255));
		it.cin = 9'($urandom_range(0, 511));
		case (it.group)
			GRP_ARITH: it.op = 5'($urandom_range(0, 10));
			GRP_MOVE:  it.op = 5'($urandom_range(0, 12));
			GRP_JUMP:  it.op = 5'($urandom_range(0, 15));
			GRP_CMP:   it.op = 5'($urandom_range(0, 23));
			default: begin
				it.op = 5'($urandom_range(0, 4));
				case (it.op)
					MSC_SYS:     it.mi = 8'($urandom_range(1, 2));
					MSC_SET_IMM: it.mi = pick_idx(16);
					MSC_GET_IMM: begin
						it.ra = pick_idx(16); it.mi = pick_idx(64);
					end
					default:     it.mi = pick_idx(64);
				endcase
			end
		endcase
		// keep a steady supply of small register values for addresses
		if ($urandom_range(0, 99) < 15) begin
			it.group = GRP_MOVE;
			it.op = MOV_SET;
			if ($urandom_range(0, 9) < 7) it.imm = 16'($urandom_range(0, 15));
		end
		return it;
	endfunction

	// an instruction that runs clean and reads only written entries
	function automatic instr_t draw_clean();
		instr_t it;
		res_t r;
		bit bad;
		for (int k = 0; k < 200; k++) begin
			it = draw_instr();
			run_instruction(it, 0, r, bad);
			if (!bad && !r.halted) return it;
		end
		it = draw_instr();
		it.group = GRP_MOVE;
		it.op = MOV_SET;
		it.ra = 8'($urandom_range(0, 63));
		it.imm = 16'($urandom_range(0, 15));
		return it;
	endfunction

	// an instruction that stops the machine, by error or terminate
	function automatic instr_t draw_halting();
		instr_t it;
		res_t r;
		bit bad;
		for (int k = 0; k < 1000; k++) begin
			it = '{group: 3'($urandom_range(0, 7)), op: 5'($urandom_range(0, 31)),
				ra: 8'($urandom_range(0, 255)), rb: 8'($urandom_range(0, 255)),
				rc: 8'($urandom_range(0, 255)), imm: 16'($urandom_range(0, 65535)),
				mi: 8'($urandom_range(0, 3)), cin: 9'($urandom_range(0, 511))};
			run_instruction(it, 0, r, bad);
			if (!bad && r.halted) return it;
		end
		it.group = 3'd7;
		return it;
	endfunction

	// drive one item after a random gap and wait for it to be taken
	task automatic offer(instr_t it, bit chk, logic [15:0] exp_pc);
		res_t r;
		bit bad;
		int gap;
		run_instruction(it, 1, r, bad);
		if (chk) r.pc = exp_pc;
		if (r.err != ERR_NONE) halt_code = r.err;
		pending_results.push_back(r);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		group      <= it.group;
		op         <= it.op;
		reg_a      <= it.ra;
		reg_b      <= it.rb;
		reg_c      <= it.rc;
		immediate  <= it.imm;
		misc_index <= it.mi;
		console_in <= it.cin;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic dir_row_t row(logic [2:0] g, logic [4:0] o, logic [7:0] a,
			logic [7:0] b, logic [7:0] c, logic [15:0] imm, logic [7:0] mi,
			logic signed [8:0] cin, logic chk, logic [15:0] exp_pc);
		dir_row_t d;
		d.ins = '{group: g, op: o, ra: a, rb: b, rc: c, imm: imm, mi: mi, cin: cin};
		d.chk = chk;
		d.exp_pc = exp_pc;
		return d;
	endfunction

	// stimulus
	initial begin
		dir_row_t plan[$];
		in_valid = 0; group = 0; op = 0; reg_a = 0; reg_b = 0; reg_c = 0;
		immediate = 0; misc_index = 0; console_in = 0;
		arst_n = 0;
		fails = 0; random_items = 0; halt_code = -1;
		mpc = 0; mstop = 0;
		foreach (mimp[i]) mimp[i] = 0;
		foreach (mreg[i]) begin
			mreg[i] = 0; mreg_ok[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// jump straight from reset to the top of the address space
		plan.push_back(row(GRP_JUMP, JMP_IMM, 0, 0, 0, 16'hFFFF, 0, 0, 1, 16'hFFFF));
		plan.push_back(row(GRP_MOVE, MOV_SET, 0, 255, 255, 16'hFFFF, 255, 0, 1, 16'h0000));
		plan.push_back(row(GRP_MOVE, MOV_SET, 63, 0, 0, 16'h0000, 0, 0, 0, 0));
		plan.push_back(row(GRP_MOVE, MOV_SET, 1, 0, 0, 16'd7, 0, 0, 0, 0));
		// divide and remainder by zero, oversized shifts
		plan.push_back(row(GRP_ARITH, ARI_DIV, 2, 1, 63, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_REM, 3, 1, 63, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_SHL, 4, 1, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_SHR, 5, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_MUL, 6, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_NOT, 7, 63, 255, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_ADD, 8, 0, 1, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_ARITH, ARI_SUB, 9, 63, 1, 0, 0, 0, 0, 0));
		// console at end of input, then a put-char of register 1
		plan.push_back(row(GRP_MISC, MSC_SYS, 10, 0, 0, 0, SYS_GETC, -9'sd1, 0, 0));
		plan.push_back(row(GRP_MISC, MSC_SYS, 1, 0, 0, 0, SYS_PUTC, 0, 0, 0));
		// memory at both ends of the address range
		plan.push_back(row(GRP_MOVE, MOV_STORE, 63, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_MOVE, MOV_STORE_IMM, 0, 0, 0, 16'h1234, 0, 0, 0, 0));
		plan.push_back(row(GRP_MOVE, MOV_SWAP_AA, 63, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_MOVE, MOV_LOAD_MEM, 11, 0, 0, 16'hFFFF, 0, 0, 0, 0));
		plan.push_back(row(GRP_MISC, MSC_SET_IMM, 1, 0, 0, 0, 15, 0, 0, 0));
		plan.push_back(row(GRP_MISC, MSC_GET_IMM, 15, 0, 0, 0, 12, 0, 0, 0));
		// link written and then read back through the same register
		plan.push_back(row(GRP_JUMP, JMP_REG_LINK, 13, 13, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_CMP, 5'({REL_LT, MODE_OR}), 0, 63, 1, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_JUMP, JMP_ITE_LINK_T, 14, 1, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(GRP_MISC, MSC_SYS, 62, 0, 0, 0, SYS_GETC, 9'sd255, 0, 0));

		foreach (plan[i]) offer(plan[i].ins, plan[i].chk, plan[i].exp_pc);

		for (random_items = 0; random_items < 1100; random_items++)
			offer(draw_clean(), 0, 0);

		// stop the machine, then confirm it stays stopped
		offer(draw_halting(), 0, 0);
		repeat (3) offer(draw_instr(), 0, 0);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d table rows and %0d random instructions, %0d results checked",
			plan.size(), random_items, results_seen);
		$display("machine stopped with error code %0d (-1 means terminate)", halt_code);
		if (fails == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endfunction

	// result side: random stalls, one long hold-off, field compare
	int hold;
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold = 0;
			results_seen = 0;
		end else if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				fails++;
			end else begin
				e = pending_results.pop_front();
				check_field("next_pc", e.pc, next_pc);
				check_field("console_out_valid", e.cov, console_out_valid);
				check_field("console_out", e.co, console_out);
				check_field("console_in_used", e.ciu, console_in_used);
				check_field("halted", e.halted, halted);
				check_field("error_code", e.err, error_code);
			end
			results_seen++;
			if (results_seen == 300) hold = 400;
			else hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			out_ready <= (hold == 0);
		end else if (hold > 0) begin
			hold--;
			out_ready <= (hold == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// run limit
	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
